FILE: rtl/wwt_pkg.sv
// Shared types, constants and elaboration-time functions for the warped-wave texture pixel.
// Used by the top level, wwt_wave and wwt_smooth; depends on nothing.
`default_nettype none

package wwt_pkg;

   // Signed Q.16 angle or value, wide enough for every warped coordinate
   typedef logic signed [27:0] ang_type;
   // Constant multiplier for a Q.16 product
   typedef logic signed [18:0] coef_type;
   // Q1.15 sine or cosine value
   typedef logic signed [15:0] wave_val_type;
   // Quarter-wave table contents
   typedef logic [14:0] wave_rom_type [1024];

   localparam int QONE = 65536;
   localparam int PIPE_DEPTH = 24;
   localparam logic [11:0] QUARTER_TURN = 12'd1024;

   // Palette split point and the width of the upper range, Q0.16
   localparam logic [16:0] SPLIT = 17'd34079;
   localparam logic [16:0] UPPER = 17'd31457;
   // Divisors of the rescale (twice the range) and their reciprocals at 2^47
   localparam logic [16:0] DIV_LOW = 17'd68158;
   localparam logic [16:0] DIV_HIGH = 17'd62914;
   localparam logic [31:0] RCP_LOW = 32'((64'd1 << 47) / 64'd68158);
   localparam logic [31:0] RCP_HIGH = 32'((64'd1 << 47) / 64'd62914);

   // Configuration register indexes
   localparam logic [1:0] CSR_LOW_COLOR = 2'd0;
   localparam logic [1:0] CSR_MID_COLOR = 2'd1;
   localparam logic [1:0] CSR_HIGH_COLOR = 2'd2;

   localparam logic [23:0] LOW_COLOR_RST = 24'h192D35;
   localparam logic [23:0] MID_COLOR_RST = 24'h486F58;
   localparam logic [23:0] HIGH_COLOR_RST = 24'hBE9E65;

   // Q.16 product with round half up (floor of the biased product)
   function automatic ang_type mulq(input coef_type c, input ang_type v);
      logic signed [47:0] p;
      p = 48'(c) * 48'(v) + 48'sd32768;
      return ang_type'(p >>> 16);
   endfunction

   // Angle in radians to a phase of 1/4096 turn, rounded half up
   function automatic logic [11:0] phase_of(input ang_type a);
      logic signed [59:0] p;
      p = 60'(a) * 60'sd42722830 + 60'sd2147483648;
      return p[43:32];
   endfunction

   // Quarter-wave sine table, Taylor series in Q2.30 rounded to Q1.15
   function automatic wave_rom_type build_wave();
      wave_rom_type t;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] s;
      logic signed [63:0] e;
      for (int i = 0; i < 1024; i++) begin
         x = (64'(i) * 64'd1686629713 + 64'd512) >> 10;
         x2 = (x * x) >> 30;
         term = x;
         s = signed'(x);
         term = ((term * x2) >> 30) / 64'd6;
         s = s - signed'(term);
         term = ((term * x2) >> 30) / 64'd20;
         s = s + signed'(term);
         term = ((term * x2) >> 30) / 64'd42;
         s = s - signed'(term);
         term = ((term * x2) >> 30) / 64'd72;
         s = s + signed'(term);
         term = ((term * x2) >> 30) / 64'd110;
         s = s - signed'(term);
         term = ((term * x2) >> 30) / 64'd156;
         s = s + signed'(term);
         e = (s + 64'sd16384) >>> 15;
         if (e > 64'sd32767) e = 64'sd32767;
         if (e < 64'sd0) e = 64'sd0;
         t[i] = 15'(e);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/warped_wave_texture_pixel_top.sv
// Top level of the warped-wave texture pixel generator: stream ports, palette registers,
// the 24-stage datapath. Uses wwt_pkg, wwt_delay, wwt_wave and wwt_smooth.
//
// Usage:
//   req_* carries one pixel coordinate per item; rsp_* returns its RGB colour.
//   One result item for every request item, in order.
//   The datapath has 24 register stages; rsp_tvalid rises once the accepted
//   item reaches the last of them. Throughput is one item per cycle while the
//   output is not stalled, set by a fully pipelined datapath: ten table-based
//   sine/cosine units, two smoothstep units and a reciprocal-multiply rescale.
//   The csr_* port writes the low, mid and high palette colours; write them
//   while no item is in flight.
//   Reset clears every stage valid bit and loads the default palette.
//   When rsp_tready is low with a result waiting, the whole pipeline holds and
//   req_tready drops; empty stages hold as well, so bubbles stay in place.
//   Nothing is dropped or repeated.
`default_nettype none

module warped_wave_texture_pixel_top #(
   parameter int PIXEL_SPAN = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import wwt_pkg::*;

   logic                  en;
   logic [PIPE_DEPTH-1:0] vld_ff;

   logic [23:0] low_color_ff;
   logic [23:0] mid_color_ff;
   logic [23:0] high_color_ff;

   logic [8:0]   x_in, y_in, x1_ff, y1_ff;
   ang_type      a1_ff, a2_ff, a3_ff, a4_ff;
   wave_val_type w1, w2, w3, w4, w5, w6, w7, w8, w9, w10;
   logic [17:0]  xy4;
   ang_type      wx_in, wy_in, wx_ff, wy_ff;
   ang_type      g1_ff, g2_ff, m1_ff, bin_ff, cin_ff, f1_ff;
   ang_type      bang_ff, cang_ff, m1_d, f1_d, bang_d, cang_d;
   ang_type      aang_ff, fang_ff;
   logic signed [17:0] sum_ff;
   logic [15:0]  fine_ff, fine_d;
   logic signed [20:0] div_m;
   logic [39:0]  quo;
   logic signed [18:0] broad_ff;
   ang_type      lay_ff;
   logic [16:0]  layer;
   ang_type      det_sum;
   logic [16:0]  det_in, det_ff;
   logic         sel_ff, sel19_ff, sel20_ff, sel23;
   logic [15:0]  dp_ff;
   logic [16:0]  q0_ff, q0_20_ff;
   logic [32:0]  n_ff, n_20_ff;
   logic [33:0]  prod_ff, diff;
   logic [16:0]  q_in;
   ang_type      q_ff;
   logic [16:0]  amt;
   logic [23:0]  rsp_in, rsp_ff;
   logic [23:0]  ca, cb;

   // pipeline advances unless a finished item is stuck at the output
   assign en = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign rsp_tdata = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   // palette registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_color_ff  <= LOW_COLOR_RST;
         mid_color_ff  <= MID_COLOR_RST;
         high_color_ff <= HIGH_COLOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_COLOR:  low_color_ff  <= csr_wdata;
            CSR_MID_COLOR:  mid_color_ff  <= csr_wdata;
            CSR_HIGH_COLOR: high_color_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // S1: coordinates reduced into the span (the loop covers values below eight spans)
   always_comb begin
      x_in = req_tdata[8:0];
      y_in = req_tdata[17:9];
      for (int i = 1; i < 8; i++) begin
         if (16'(req_tdata[8:0]) >= 16'(i * PIXEL_SPAN)) x_in = 9'(req_tdata[8:0] - 9'(i * PIXEL_SPAN));
         if (16'(req_tdata[17:9]) >= 16'(i * PIXEL_SPAN)) y_in = 9'(req_tdata[17:9] - 9'(i * PIXEL_SPAN));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x_in;
         y1_ff <= y_in;
      end
   end

   // S2: warp angles, exact on integer coordinates
   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff <= ang_type'(1769 * y1_ff);
         a2_ff <= ang_type'(3998 * x1_ff + 1245 * y1_ff);
         a3_ff <= ang_type'(1638 * x1_ff);
         a4_ff <= ang_type'(1442 * x1_ff - 3736 * y1_ff);
      end
   end

   wwt_wave u_wave1 (.clock, .en, .cos_sel(1'b0), .angle(a1_ff), .value(w1));
   wwt_wave u_wave2 (.clock, .en, .cos_sel(1'b0), .angle(a2_ff), .value(w2));
   wwt_wave u_wave3 (.clock, .en, .cos_sel(1'b1), .angle(a3_ff), .value(w3));
   wwt_wave u_wave4 (.clock, .en, .cos_sel(1'b0), .angle(a4_ff), .value(w4));

   wwt_delay #(.WIDTH(18), .DEPTH(3)) u_dly_xy (
      .clock, .en, .din({y1_ff, x1_ff}), .dout(xy4)
   );

   // S5: warped coordinates
   assign wx_in = ang_type'({xy4[8:0], 16'h0}) + (ang_type'(w1) <<< 4)
                + ang_type'(w2) * ang_type'(7);
   assign wy_in = ang_type'({xy4[17:9], 16'h0}) + ang_type'(w3) * ang_type'(14)
                - ang_type'(w4) * ang_type'(6);

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
      end
   end

   // S6: first products of the warped coordinates
   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff  <= mulq(coef_type'(2032), wy_ff);
         g2_ff  <= mulq(coef_type'(3080), wy_ff);
         m1_ff  <= mulq(coef_type'(6881), wx_ff);
         bin_ff <= mulq(coef_type'(-34079), wx_ff) + mulq(coef_type'(55968), wy_ff);
         cin_ff <= mulq(coef_type'(39977), wx_ff) + mulq(coef_type'(51970), wy_ff);
         f1_ff  <= mulq(coef_type'(11534), wx_ff) - mulq(coef_type'(9372), wy_ff);
      end
   end

   wwt_wave u_wave5 (.clock, .en, .cos_sel(1'b0), .angle(g1_ff), .value(w5));
   wwt_wave u_wave6 (.clock, .en, .cos_sel(1'b0), .angle(g2_ff), .value(w6));

   // S7: rotated-wave angles
   always_ff @(posedge clock) begin
      if (en) begin
         bang_ff <= mulq(coef_type'(6291), bin_ff) + ang_type'(58982);
         cang_ff <= mulq(coef_type'(5833), cin_ff) - ang_type'(45875);
      end
   end

   wwt_delay #(.WIDTH(56), .DEPTH(2)) u_dly_mf (
      .clock, .en, .din({m1_ff, f1_ff}), .dout({m1_d, f1_d})
   );
   wwt_delay #(.WIDTH(56), .DEPTH(2)) u_dly_bc (
      .clock, .en, .din({bang_ff, cang_ff}), .dout({bang_d, cang_d})
   );

   // S9: angles with the inner sine folded in
   always_ff @(posedge clock) begin
      if (en) begin
         aang_ff <= m1_d + mulq(coef_type'(22938), ang_type'(w5) <<< 1);
         fang_ff <= f1_d + mulq(coef_type'(38011), ang_type'(w6) <<< 1);
      end
   end

   wwt_wave u_wave7  (.clock, .en, .cos_sel(1'b1), .angle(aang_ff), .value(w7));
   wwt_wave u_wave8  (.clock, .en, .cos_sel(1'b1), .angle(bang_d),  .value(w8));
   wwt_wave u_wave9  (.clock, .en, .cos_sel(1'b1), .angle(cang_d),  .value(w9));
   wwt_wave u_wave10 (.clock, .en, .cos_sel(1'b0), .angle(fang_ff), .value(w10));

   // S12: broad sum and fine layer
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= 18'(w7) + 18'(w8) + 18'(w9);
         fine_ff <= 16'(18'sd32768 + 18'(w10));
      end
   end

   // S13: broad = floor((2*sum + 1) / 3), biased positive for a reciprocal multiply
   assign div_m = 21'(sum_ff) * 21'sd2 + 21'sd1 + 21'sd393216;
   assign quo = 40'(div_m[19:0]) * 40'd699051;

   always_ff @(posedge clock) begin
      if (en) broad_ff <= signed'(quo[39:21]) - 19'sd131072;
   end

   // S14: layer argument
   always_ff @(posedge clock) begin
      if (en) lay_ff <= ang_type'(31457) + mulq(coef_type'(27525), ang_type'(broad_ff));
   end

   wwt_smooth u_smooth_layer (.clock, .en, .arg(lay_ff), .result(layer));

   wwt_delay #(.WIDTH(16), .DEPTH(4)) u_dly_fine (
      .clock, .en, .din(fine_ff), .dout(fine_d)
   );

   // S17: detail, clamped to [0,1]
   assign det_sum = mulq(coef_type'(55050), ang_type'(layer))
                  + mulq(coef_type'(10486), ang_type'(fine_d));
   assign det_in = (det_sum < 0) ? 17'd0 :
                   (det_sum > ang_type'(QONE)) ? 17'd65536 : det_sum[16:0];

   always_ff @(posedge clock) begin
      if (en) det_ff <= det_in;
   end

   // S18: palette half and offset within it
   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff <= (det_ff >= SPLIT);
         dp_ff  <= (det_ff >= SPLIT) ? 16'(det_ff - SPLIT) : det_ff[15:0];
      end
   end

   // S19: quotient estimate, never above the rounded quotient and at most one below
   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff    <= 17'((48'(dp_ff) * 48'(sel_ff ? RCP_HIGH : RCP_LOW)) >> 30);
         n_ff     <= {dp_ff, 17'h0} + 33'(sel_ff ? UPPER : SPLIT);
         sel19_ff <= sel_ff;
      end
   end

   // S20: back-multiply
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= 34'(q0_ff) * 34'(sel19_ff ? DIV_HIGH : DIV_LOW);
         q0_20_ff <= q0_ff;
         n_20_ff  <= n_ff;
         sel20_ff <= sel19_ff;
      end
   end

   // S21: one correction step
   assign diff = 34'(n_20_ff) - prod_ff;
   assign q_in = (diff >= 34'(sel20_ff ? DIV_HIGH : DIV_LOW)) ? 17'(q0_20_ff + 17'd1) : q0_20_ff;

   always_ff @(posedge clock) begin
      if (en) q_ff <= ang_type'(q_in);
   end

   wwt_smooth u_smooth_amt (.clock, .en, .arg(q_ff), .result(amt));

   wwt_delay #(.WIDTH(1), .DEPTH(3)) u_dly_sel (
      .clock, .en, .din(sel20_ff), .dout(sel23)
   );

   // S24: per-channel blend, red in the top byte of a palette word
   assign ca = sel23 ? mid_color_ff : low_color_ff;
   assign cb = sel23 ? high_color_ff : mid_color_ff;

   always_comb begin
      logic [25:0] mix;
      logic [16:0] inv;
      rsp_in = '0;
      inv = 17'(18'd65536 - 18'(amt));
      for (int c = 0; c < 3; c++) begin
         mix = 26'(ca[23-8*c -: 8]) * 26'(inv) + 26'(cb[23-8*c -: 8]) * 26'(amt) + 26'd32768;
         rsp_in[8*c +: 8] = mix[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: rtl/wwt_delay.sv
// Stall-aware delay line that carries payload alongside the main pipeline.
// Depends on nothing.
`default_nettype none

module wwt_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift one stage per advancing cycle
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/wwt_wave.sv
// Sine/cosine unit: phase multiply, quarter-wave table read, sign fold.
// Two register stages; uses wwt_pkg for the table builder and phase mapping.
`default_nettype none

module wwt_wave (
   input  logic                  clock,
   input  logic                  en,
   input  logic                  cos_sel,
   input  wwt_pkg::ang_type      angle,
   output wwt_pkg::wave_val_type value
);
   import wwt_pkg::*;

   localparam wave_rom_type WAVE_ROM = build_wave();

   logic [11:0] phase_in;
   logic [11:0] phase_ff;
   logic [9:0]  addr;
   logic        full;
   logic [14:0] rom_ff;
   logic        full_ff;
   logic        neg_ff;
   logic [14:0] mag;

   // stage 1: angle to phase, cosine is a quarter turn ahead
   assign phase_in = phase_of(angle) + (cos_sel ? QUARTER_TURN : 12'd0);

   always_ff @(posedge clock) begin
      if (en) phase_ff <= phase_in;
   end

   // stage 2: mirror odd quadrants; the quarter point itself is full scale
   assign addr = phase_ff[10] ? 10'(10'd0 - phase_ff[9:0]) : phase_ff[9:0];
   assign full = phase_ff[10] && (phase_ff[9:0] == 10'd0);

   always_ff @(posedge clock) begin
      if (en) begin
         rom_ff  <= WAVE_ROM[addr];
         full_ff <= full;
         neg_ff  <= phase_ff[11];
      end
   end

   // second half of the turn (phase bit 11 set) is negative
   assign mag = full_ff ? 15'h7FFF : rom_ff;
   assign value = neg_ff ? -wave_val_type'({1'b0, mag}) : wave_val_type'({1'b0, mag});

endmodule

`default_nettype wire

FILE: rtl/wwt_smooth.sv
// Two-stage smoothstep on a Q.16 argument clamped to [0,1].
// Uses wwt_pkg for the angle type.
`default_nettype none

module wwt_smooth (
   input  logic             clock,
   input  logic             en,
   input  wwt_pkg::ang_type arg,
   output logic [16:0]      result
);
   import wwt_pkg::*;

   logic [16:0] t_in;
   logic [16:0] t2_in;
   logic [16:0] t_ff;
   logic [16:0] t2_ff;
   logic [17:0] slope;
   logic [34:0] prod;
   logic [16:0] result_in;
   logic [16:0] result_ff;

   // stage 1: clamp and square
   assign t_in = (arg < 0) ? 17'd0 :
                 (arg > ang_type'(QONE)) ? 17'd65536 : arg[16:0];
   assign t2_in = 17'((34'(t_in) * 34'(t_in) + 34'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= t_in;
         t2_ff <= t2_in;
      end
   end

   // stage 2: t^2 * (3 - 2t)
   assign slope = 18'd196608 - {t_ff, 1'b0};
   assign prod = 35'(t2_ff) * 35'(slope);
   assign result_in = 17'((prod + 35'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (en) result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

FILE: rtl/wwt_checker.sv
// Port-level checks for the warped-wave texture pixel top, bound to it.
// Depends only on the top level's ports.
`default_nettype none

module wwt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an empty output never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // a draining output never blocks the input
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input blocked while output drains");

endmodule

bind warped_wave_texture_pixel_top wwt_checker u_wwt_checker (.*);

`default_nettype wire
